// ===== sv/pcsm_pkg.sv =====
// Shared constants and item types for the PNG chunk scan and mask block.
package pcsm_pkg;

   localparam int unsigned COUNT_MAX = 255;
   localparam logic [7:0] COUNT_LIMIT = (COUNT_MAX > 255) ? 8'd255 : 8'(COUNT_MAX);

   localparam logic [31:0] TAG_IDAT = 32'h4944_4154;
   localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
   localparam logic [31:0] HDR_LEN = 32'd13;
   localparam logic [3:0] HDR_LAST_OFFSET = 4'd12;
   localparam logic [3:0] HDR_WORD1_OFFSET = 4'd8;
   localparam int unsigned HDR_BYTE_COUNT = 5;
   localparam int unsigned HDR_BYTE_W = $clog2(HDR_BYTE_COUNT);

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        is_idat;
      logic        is_ihdr;
      logic [31:0] length;
   } scan_item_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        masked;
      logic        out_last;
      logic [31:0] img_width;
      logic [31:0] img_height;
      logic [7:0]  bit_depth;
      logic [7:0]  colour_type;
      logic [7:0]  compression_kind;
      logic [7:0]  filter_kind;
      logic [7:0]  interlace_kind;
      logic [1:0]  header_status;
      logic [7:0]  data_chunks;
   } result_type;

endpackage

// ===== sv/pcsm_front.sv =====
// Front end: byte history, tag classification and the queue toward the back end.
module pcsm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [7:0]              in_byte,
   input  logic                    in_last,
   output pcsm_pkg::scan_item_type item,
   output logic                    item_valid,
   input  logic                    item_take
);
   import pcsm_pkg::*;

   logic [63:0]   history_ff;
   logic [63:0]   history_in;
   scan_item_type queue_ff [QUEUE_DEPTH];
   scan_item_type new_item;
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic          push_ok;
   logic          take_ok;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign push_ok    = push && !full;
   assign take_ok    = item_take && item_valid;
   assign item       = queue_ff[rd_ptr_ff];

   assign history_in = {history_ff[55:0], in_byte};

   always_comb begin
      new_item.data    = in_byte;
      new_item.last    = in_last;
      new_item.is_idat = (history_in[31:0] == TAG_IDAT);
      new_item.is_ihdr = (history_in[31:0] == TAG_IHDR);
      new_item.length  = history_in[63:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         if (push_ok) begin
            history_ff          <= history_in;
            queue_ff[wr_ptr_ff] <= new_item;
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (take_ok) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_ok && !take_ok) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push_ok && take_ok) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== sv/pcsm_back.sv =====
// Back end: masking, header capture, tag count and the result queue.
module pcsm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  pcsm_pkg::scan_item_type item,
   input  logic                    item_valid,
   output logic                    item_take,
   output pcsm_pkg::result_type    result,
   output logic                    empty,
   input  logic                    pop
);
   import pcsm_pkg::*;

   typedef enum logic [1:0] {
      HDR_IDLE = 2'd0,
      HDR_READ = 2'd1,
      HDR_DONE = 2'd2,
      HDR_BAD  = 2'd3
   } hdr_state_type;

   logic [31:0]   mask_ff,   mask_in;
   hdr_state_type hdr_ff,    hdr_in;
   logic [3:0]    offset_ff, offset_in;
   logic [63:0]   dims_ff,   dims_in;
   logic [HDR_BYTE_COUNT-1:0][7:0] bytes_ff, bytes_in;
   logic [7:0]    tags_ff,   tags_in;
   logic [31:0]   mask_dec;
   logic          is_masked;
   logic [HDR_BYTE_W-1:0] byte_off;
   result_type    res_in;

   result_type        queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              res_full;
   logic              pop_ok;

   assign res_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_ok    = pop && !empty;
   assign item_take = item_valid && !res_full;
   assign result    = queue_ff[rd_ptr_ff];
   assign byte_off  = HDR_BYTE_W'(offset_ff - HDR_WORD1_OFFSET);

   always_comb begin
      is_masked = (mask_ff != '0);
      mask_dec  = is_masked ? mask_ff - 32'd1 : mask_ff;
      mask_in   = mask_dec;
      hdr_in    = hdr_ff;
      offset_in = offset_ff;
      dims_in   = dims_ff;
      bytes_in  = bytes_ff;
      tags_in   = tags_ff;

      // capture this byte while reading the header
      if (hdr_ff == HDR_READ) begin
         if (offset_ff < HDR_WORD1_OFFSET) begin
            dims_in = {dims_ff[55:0], item.data};
         end else begin
            bytes_in[byte_off] = item.data;
         end
         if (offset_ff == HDR_LAST_OFFSET) begin
            hdr_in    = HDR_DONE;
            offset_in = '0;
         end else begin
            offset_in = offset_ff + 4'd1;
         end
      end

      if (item.is_idat) begin
         if (tags_ff < COUNT_LIMIT) begin
            tags_in = tags_ff + 8'd1;
         end
         if (item.length > mask_dec) begin
            mask_in = item.length;
         end
      end

      if (item.is_ihdr && (hdr_in == HDR_IDLE)) begin
         if (item.length == HDR_LEN) begin
            hdr_in    = HDR_READ;
            offset_in = '0;
         end else begin
            hdr_in = HDR_BAD;
         end
      end

      res_in.out_byte         = is_masked ? 8'd0 : item.data;
      res_in.masked           = is_masked;
      res_in.out_last         = item.last;
      res_in.img_width        = dims_in[63:32];
      res_in.img_height       = dims_in[31:0];
      res_in.bit_depth        = bytes_in[0];
      res_in.colour_type      = bytes_in[1];
      res_in.compression_kind = bytes_in[2];
      res_in.filter_kind      = bytes_in[3];
      res_in.interlace_kind   = bytes_in[4];
      res_in.header_status    = hdr_in;
      res_in.data_chunks      = tags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '0;
         hdr_ff    <= HDR_IDLE;
         offset_ff <= '0;
         dims_ff   <= '0;
         bytes_ff  <= '0;
         tags_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (item_take) begin
            mask_ff             <= mask_in;
            hdr_ff              <= hdr_in;
            offset_ff           <= offset_in;
            dims_ff             <= dims_in;
            bytes_ff            <= bytes_in;
            tags_ff             <= tags_in;
            queue_ff[wr_ptr_ff] <= res_in;
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (item_take && !pop_ok) begin
            count_ff <= count_ff + 1'b1;
         end else if (!item_take && pop_ok) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== sv/png_chunk_scan_and_mask_core.sv =====
// Top level of the PNG chunk scanner and IDAT payload masker.
// Takes one file byte per item and returns one result item per byte, one item
// per clock sustained while neither queue is full. The front end shifts the
// byte history and classifies IHDR/IDAT tags into a two-entry queue; the back
// end applies the mask count, header capture and tag count per item and writes
// into a two-entry result queue, whose head drives the rsp_ ports. The back
// end's state update sets the rate. Results carry the header fields and
// status as they stand after the byte.
module png_chunk_scan_and_mask_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_masked,
   output logic        rsp_out_last,
   output logic [31:0] rsp_img_width,
   output logic [31:0] rsp_img_height,
   output logic [7:0]  rsp_bit_depth,
   output logic [7:0]  rsp_colour_type,
   output logic [7:0]  rsp_compression_kind,
   output logic [7:0]  rsp_filter_kind,
   output logic [7:0]  rsp_interlace_kind,
   output logic [1:0]  rsp_header_status,
   output logic [7:0]  rsp_data_chunks
);
   import pcsm_pkg::*;

   scan_item_type scan_item;
   logic          scan_valid;
   logic          scan_take;
   result_type    result;

   pcsm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .in_byte    (req_in_byte),
      .in_last    (req_in_last),
      .item       (scan_item),
      .item_valid (scan_valid),
      .item_take  (scan_take)
   );

   pcsm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (scan_item),
      .item_valid (scan_valid),
      .item_take  (scan_take),
      .result     (result),
      .empty      (rsp_empty),
      .pop        (rsp_pop)
   );

   assign rsp_out_byte         = result.out_byte;
   assign rsp_masked           = result.masked;
   assign rsp_out_last         = result.out_last;
   assign rsp_img_width        = result.img_width;
   assign rsp_img_height       = result.img_height;
   assign rsp_bit_depth        = result.bit_depth;
   assign rsp_colour_type      = result.colour_type;
   assign rsp_compression_kind = result.compression_kind;
   assign rsp_filter_kind      = result.filter_kind;
   assign rsp_interlace_kind   = result.interlace_kind;
   assign rsp_header_status    = result.header_status;
   assign rsp_data_chunks      = result.data_chunks;

endmodule
